@@ sv/pcm_decode_linear_resampler_assert.svh @@
// Assertion macros for the resampler checker.
// Standalone header; included by pdlr_checker.sv.
`ifndef PCM_DECODE_LINEAR_RESAMPLER_ASSERT_SVH
`define PCM_DECODE_LINEAR_RESAMPLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDLR_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDLR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pdlr_pkg.sv @@
// Shared types, widths and codes for the PCM decode and linear resampler.
// No dependencies; the interfaces, decoder, multiplier, top level and checker use it by scoped names.
`timescale 1ns / 1ps

package pdlr_pkg;

    localparam int FRAC_BITS = 16;

    localparam int RAW_W     = 32;
    localparam int Q_W       = 34;
    localparam int FMT_W     = 3;
    localparam int CNT_W     = 4;
    localparam int RATE_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int OUT_W     = 16;

    localparam int STEP_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int STEP_SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int WIDE_W   = RATE_W + STEP_SHL;
    localparam int STEP_W   = RATE_W + STEP_SHL - STEP_SHR;
    localparam int POS_W    = STEP_W + 1;

    localparam int DIFF_W = Q_W + 1;
    localparam int MB_W   = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 1;
    localparam int PROD_W = DIFF_W + MB_W;

    localparam logic [RATE_W-1:0] STEP_MIN   = RATE_W'(4096);
    localparam logic [POS_W-1:0]  POS_ONE    = POS_W'(1) << FRAC_BITS;
    localparam int                Q_SCALE    = 32767;
    localparam int                Q_ONE_BITS = 31;

    typedef enum logic [FMT_W-1:0] {
        FMT_FLOAT32 = 3'd0,
        FMT_UINT8   = 3'd1,
        FMT_INT16   = 3'd2,
        FMT_INT24P  = 3'd3,
        FMT_INT24W  = 3'd4,
        FMT_INT32   = 3'd5,
        FMT_NONE    = 3'd6
    } fmt_t;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd2;

    localparam logic [CNT_W-1:0]  CHANNELS_RESET = 4'd2;
    localparam logic [RATE_W-1:0] RATE_RESET     = 20'd65536;

endpackage

@@ sv/pdlr_ifs.sv @@
// Valid/ready channel interfaces: input frames, output samples, register writes.
// Depends on pdlr_pkg for field widths.
`timescale 1ns / 1ps

interface pdlr_frame_if;
    logic                          valid;
    logic                          ready;
    logic [pdlr_pkg::RAW_W-1:0]    left_raw;
    logic [pdlr_pkg::RAW_W-1:0]    right_raw;
    logic                          packet_silent;
    logic                          packet_last;

    modport source (output valid, left_raw, right_raw, packet_silent, packet_last,
                    input ready);
    modport sink   (input valid, left_raw, right_raw, packet_silent, packet_last,
                    output ready);
endinterface

interface pdlr_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [pdlr_pkg::OUT_W-1:0] left_sample;
    logic signed [pdlr_pkg::OUT_W-1:0] right_sample;
    logic                              last_of_run;

    modport source (output valid, left_sample, right_sample, last_of_run, input ready);
    modport sink   (input valid, left_sample, right_sample, last_of_run, output ready);
endinterface

interface pdlr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pdlr_pkg::CFG_IDX_W-1:0]   index;
    logic [pdlr_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/pdlr_decode.sv @@
// Sample decoder: one raw container to signed Q2.31 by the configured format.
// Depends on pdlr_pkg.
`timescale 1ns / 1ps

module pdlr_decode (
    input  logic [pdlr_pkg::RAW_W-1:0]    raw,
    input  pdlr_pkg::fmt_t                fmt,
    output logic signed [pdlr_pkg::Q_W-1:0] value
);

    localparam int EXT_W = pdlr_pkg::Q_W - pdlr_pkg::RAW_W;
    localparam logic signed [pdlr_pkg::Q_W-1:0] Q_MAX = {1'b0, {(pdlr_pkg::Q_W-1){1'b1}}};
    localparam logic signed [pdlr_pkg::Q_W-1:0] Q_MIN = {1'b1, {(pdlr_pkg::Q_W-1){1'b0}}};
    localparam logic [7:0] EXP_MAX  = 8'hFF;
    localparam logic [7:0] EXP_BASE = 8'd119;

    logic [7:0]                     expo;
    logic [23:0]                    mant;
    logic                           neg;
    logic [7:0]                     sh;
    logic [pdlr_pkg::Q_W-1:0]       mag;
    logic                           sat;
    logic signed [pdlr_pkg::Q_W-1:0] fval;

    always_comb
    begin
        expo = raw[30:23];
        mant = {1'b1, raw[22:0]};
        neg  = raw[31];
        sh   = '0;
        mag  = '0;
        sat  = 1'b0;
        if (expo == EXP_MAX)
        begin
            sat = (raw[22:0] == '0);
        end
        else if (expo == '0)
        begin
            mag = '0;
        end
        else if (expo >= EXP_BASE)
        begin
            sh = expo - EXP_BASE;
            if (sh > 8'd9)
            begin
                sat = 1'b1;
            end
            else
            begin
                mag = pdlr_pkg::Q_W'(mant) << sh[3:0];
                sat = mag[pdlr_pkg::Q_W-1];
            end
        end
        else
        begin
            sh  = EXP_BASE - expo;
            mag = (sh >= 8'd32) ? '0 : pdlr_pkg::Q_W'(mant >> sh[4:0]);
        end

        if (sat)
            fval = neg ? Q_MIN : Q_MAX;
        else
            fval = neg ? -$signed(mag) : $signed(mag);
    end

    always_comb
    begin
        unique case (fmt)
            pdlr_pkg::FMT_FLOAT32: value = fval;
            pdlr_pkg::FMT_UINT8:   value = {{(EXT_W+1){~raw[7]}}, raw[6:0], 24'b0};
            pdlr_pkg::FMT_INT16:   value = {{(EXT_W){raw[15]}}, raw[15:0], 16'b0};
            pdlr_pkg::FMT_INT24P:  value = {{(EXT_W){raw[23]}}, raw[23:0], 8'b0};
            pdlr_pkg::FMT_INT24W:  value = {{(EXT_W){raw[31]}}, raw[31:8], 8'b0};
            pdlr_pkg::FMT_INT32:   value = {{(EXT_W){raw[31]}}, raw};
            default:               value = '0;
        endcase
    end

endmodule

@@ sv/pdlr_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on pdlr_pkg for operand widths.
`timescale 1ns / 1ps

module pdlr_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [pdlr_pkg::DIFF_W-1:0]    a,
    input  logic signed [pdlr_pkg::MB_W-1:0]      b,
    output logic signed [pdlr_pkg::PROD_W-1:0]    prod
);

    always_ff @(posedge clk)
    begin
        if (en)
            prod <= a * b;
    end

endmodule

@@ sv/pcm_decode_linear_resampler.sv @@
// Top level of the PCM decode and linear resampler: sequencer and registers.
// Depends on pdlr_pkg, pdlr_ifs, pdlr_decode and pdlr_mul.
//
// One frame is taken when frame.ready is high; the block then decodes left and right
// in turn through one decoder, and produces its results through one shared
// multiplier that forms four products per result (two interpolations, two scalings).
// A finished result waits while the result channel has not taken the last one. Results
// leave through an output register, so the next frame is taken while the last result
// still waits. Register writes are taken at any time and apply at once; write them only
// while no frame is in flight.
`timescale 1ns / 1ps

module pcm_decode_linear_resampler (
    input  logic                  clk,
    input  logic                  rst_n,
    pdlr_frame_if.sink            frame,
    pdlr_result_if.source         result,
    pdlr_cfg_if.sink              cfg
);

    localparam int Q_W    = pdlr_pkg::Q_W;
    localparam int DIFF_W = pdlr_pkg::DIFF_W;
    localparam int MB_W   = pdlr_pkg::MB_W;
    localparam int PROD_W = pdlr_pkg::PROD_W;
    localparam int POS_W  = pdlr_pkg::POS_W;
    localparam int OUT_W  = pdlr_pkg::OUT_W;
    localparam int FRAC   = pdlr_pkg::FRAC_BITS;
    localparam int QB     = pdlr_pkg::Q_ONE_BITS;

    localparam logic signed [PROD_W-1:0] FRAC_BIAS = PROD_W'((64'd1 << FRAC) - 64'd1);
    localparam logic signed [PROD_W-1:0] QNT_BIAS  = PROD_W'((64'd1 << QB) - 64'd1);
    localparam logic signed [Q_W-1:0]    Q_HI      = Q_W'(64'd1 << QB);
    localparam logic signed [Q_W-1:0]    Q_LO      = -Q_HI;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC_L, S_DEC_R, S_START, S_LOOP,
        S_ML, S_MR, S_QL, S_QR, S_EMIT
    } state_t;

    state_t                      state_reg;
    pdlr_pkg::fmt_t              fmt_reg;
    logic [pdlr_pkg::CNT_W-1:0]  chan_reg;
    logic [pdlr_pkg::RATE_W-1:0] rate_reg;

    logic [pdlr_pkg::RAW_W-1:0]  raw_l_reg;
    logic [pdlr_pkg::RAW_W-1:0]  raw_r_reg;
    logic                        silent_reg;
    logic                        last_reg;
    logic signed [Q_W-1:0]       cur_l_reg;
    logic signed [Q_W-1:0]       cur_r_reg;
    logic signed [Q_W-1:0]       prev_l_reg;
    logic signed [Q_W-1:0]       prev_r_reg;
    logic                        have_prev_reg;
    logic                        phase_reg;
    logic [POS_W-1:0]            pos_reg;
    logic signed [Q_W-1:0]       il_reg;
    logic signed [Q_W-1:0]       ir_reg;
    logic signed [OUT_W-1:0]     ql_reg;
    logic                        out_valid_reg;
    logic signed [OUT_W-1:0]     out_l_reg;
    logic signed [OUT_W-1:0]     out_r_reg;
    logic                        out_last_reg;

    logic [pdlr_pkg::RAW_W-1:0]  dec_raw;
    logic signed [Q_W-1:0]       dec_val;
    logic signed [Q_W-1:0]       a_l;
    logic signed [Q_W-1:0]       a_r;
    logic signed [DIFF_W-1:0]    mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic                        mul_en;
    logic signed [PROD_W-1:0]    prod;
    logic [pdlr_pkg::RATE_W-1:0] rate_eff;
    logic [pdlr_pkg::WIDE_W-1:0] step_wide;
    logic [POS_W-1:0]            step;
    logic [POS_W-1:0]            next_pos;
    logic                        is_last;
    logic                        out_free;
    logic                        emit_fire;

    function automatic logic signed [Q_W-1:0] interp_add(
        input logic signed [Q_W-1:0]    base,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] sh;
        logic signed [Q_W:0]      sum;
        sh  = (p + (p[PROD_W-1] ? FRAC_BIAS : '0)) >>> FRAC;
        sum = {base[Q_W-1], base} + sh[Q_W:0];
        return sum[Q_W-1:0];
    endfunction

    function automatic logic signed [DIFF_W-1:0] clamp_unit(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] c;
        c = v;
        if (v > Q_HI)
            c = Q_HI;
        if (v < Q_LO)
            c = Q_LO;
        return DIFF_W'(c);
    endfunction

    function automatic logic signed [OUT_W-1:0] quant(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = (p + (p[PROD_W-1] ? QNT_BIAS : '0)) >>> QB;
        return sh[OUT_W-1:0];
    endfunction

    pdlr_decode u_decode (
        .raw   (dec_raw),
        .fmt   (fmt_reg),
        .value (dec_val)
    );

    pdlr_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        dec_raw   = (state_reg == S_DEC_R) ? raw_r_reg : raw_l_reg;
        a_l       = phase_reg ? cur_l_reg : prev_l_reg;
        a_r       = phase_reg ? cur_r_reg : prev_r_reg;
        rate_eff  = (rate_reg < pdlr_pkg::STEP_MIN) ? pdlr_pkg::STEP_MIN : rate_reg;
        step_wide = pdlr_pkg::WIDE_W'(rate_eff) << pdlr_pkg::STEP_SHL;
        step      = POS_W'(step_wide >> pdlr_pkg::STEP_SHR);
        next_pos  = pos_reg + step;
        is_last   = (next_pos >= pdlr_pkg::POS_ONE)
                    && !(!phase_reg && last_reg
                         && ((next_pos - pdlr_pkg::POS_ONE) < pdlr_pkg::POS_ONE));
        out_free  = !out_valid_reg || result.ready;
        emit_fire = (state_reg == S_EMIT) && out_free;

        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_ML:
            begin
                mul_en = 1'b1;
                mul_a  = DIFF_W'(cur_l_reg) - DIFF_W'(a_l);
                mul_b  = MB_W'(pos_reg[FRAC-1:0]);
            end
            S_MR:
            begin
                mul_en = 1'b1;
                mul_a  = DIFF_W'(cur_r_reg) - DIFF_W'(a_r);
                mul_b  = MB_W'(pos_reg[FRAC-1:0]);
            end
            S_QL:
            begin
                mul_en = 1'b1;
                mul_a  = clamp_unit(il_reg);
                mul_b  = MB_W'(pdlr_pkg::Q_SCALE);
            end
            S_QR:
            begin
                mul_en = 1'b1;
                mul_a  = clamp_unit(ir_reg);
                mul_b  = MB_W'(pdlr_pkg::Q_SCALE);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= pdlr_pkg::FMT_INT16;
            chan_reg <= pdlr_pkg::CHANNELS_RESET;
            rate_reg <= pdlr_pkg::RATE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pdlr_pkg::REG_FORMAT:   fmt_reg  <= pdlr_pkg::fmt_t'(cfg.data[pdlr_pkg::FMT_W-1:0]);
                pdlr_pkg::REG_CHANNELS: chan_reg <= cfg.data[pdlr_pkg::CNT_W-1:0];
                pdlr_pkg::REG_RATE:     rate_reg <= cfg.data[pdlr_pkg::RATE_W-1:0];
                default:                rate_reg <= rate_reg;
            endcase
        end
    end

    // Sequencer, state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            raw_l_reg     <= '0;
            raw_r_reg     <= '0;
            silent_reg    <= 1'b0;
            last_reg      <= 1'b0;
            cur_l_reg     <= '0;
            cur_r_reg     <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            have_prev_reg <= 1'b0;
            phase_reg     <= 1'b0;
            pos_reg       <= '0;
            il_reg        <= '0;
            ir_reg        <= '0;
            ql_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_l_reg     <= '0;
            out_r_reg     <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= emit_fire || (out_valid_reg && !result.ready);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (frame.valid)
                    begin
                        raw_l_reg  <= frame.left_raw;
                        raw_r_reg  <= frame.right_raw;
                        silent_reg <= frame.packet_silent;
                        last_reg   <= frame.packet_last;
                        state_reg  <= S_DEC_L;
                    end
                end
                S_DEC_L:
                begin
                    cur_l_reg <= silent_reg ? '0 : dec_val;
                    state_reg <= S_DEC_R;
                end
                S_DEC_R:
                begin
                    if (silent_reg)
                        cur_r_reg <= '0;
                    else if (chan_reg > pdlr_pkg::CNT_W'(1))
                        cur_r_reg <= dec_val;
                    else
                        cur_r_reg <= cur_l_reg;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    if (have_prev_reg)
                    begin
                        phase_reg <= 1'b0;
                        state_reg <= S_LOOP;
                    end
                    else if (last_reg)
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= S_LOOP;
                    end
                    else
                    begin
                        prev_l_reg    <= cur_l_reg;
                        prev_r_reg    <= cur_r_reg;
                        have_prev_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_LOOP:
                begin
                    if (pos_reg < pdlr_pkg::POS_ONE)
                    begin
                        state_reg <= S_ML;
                    end
                    else
                    begin
                        pos_reg <= pos_reg - pdlr_pkg::POS_ONE;
                        if (!phase_reg && last_reg)
                        begin
                            phase_reg <= 1'b1;
                        end
                        else
                        begin
                            // Close the frame: hold it, or drop it at packet end.
                            have_prev_reg <= !last_reg;
                            prev_l_reg    <= last_reg ? '0 : cur_l_reg;
                            prev_r_reg    <= last_reg ? '0 : cur_r_reg;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_ML:
                begin
                    state_reg <= S_MR;
                end
                S_MR:
                begin
                    il_reg    <= interp_add(a_l, prod);
                    state_reg <= S_QL;
                end
                S_QL:
                begin
                    ir_reg    <= interp_add(a_r, prod);
                    state_reg <= S_QR;
                end
                S_QR:
                begin
                    ql_reg    <= quant(prod);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_l_reg     <= ql_reg;
                        out_r_reg     <= quant(prod);
                        out_last_reg  <= is_last;
                        pos_reg       <= next_pos;
                        state_reg     <= S_LOOP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign frame.ready         = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.left_sample  = out_l_reg;
    assign result.right_sample = out_r_reg;
    assign result.last_of_run  = out_last_reg;

endmodule

@@ sv/pdlr_checker.sv @@
// Port-level checker for the resampler, bound to the top level.
// Depends on pcm_decode_linear_resampler_assert.svh and pdlr_pkg.
`timescale 1ns / 1ps
`include "pcm_decode_linear_resampler_assert.svh"

module pdlr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [pdlr_pkg::OUT_W-1:0] left_sample,
    input logic signed [pdlr_pkg::OUT_W-1:0] right_sample,
    input logic                              last_of_run
);

    `PDLR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(left_sample) && $stable(right_sample) && $stable(last_of_run), "result changed while stalled")
    `PDLR_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "frame taken while decoding")
    `PDLR_ASSERT_IMP(a_sample_range, clk, rst_n, out_valid, (left_sample != 16'h8000) && (right_sample != 16'h8000), "sample beyond unit range")

endmodule

bind pcm_decode_linear_resampler pdlr_checker u_pdlr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (frame.valid),
    .in_ready     (frame.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .left_sample  (result.left_sample),
    .right_sample (result.right_sample),
    .last_of_run  (result.last_of_run)
);
